// ===== rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// shared constants and types for the first-fit block allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int unsigned HEAP_LIMIT_BYTES = 65536;
  localparam int unsigned GROW_STEP_BYTES  = 4096;
  localparam int unsigned HEADER_BYTES     = 16;
  localparam int unsigned MAX_BLOCKS       = 256;

  localparam int unsigned OFS_W = 17;
  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SUM_W = 20;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_RESULT
  } state_e;

  // search word handed from cell to cell
  typedef struct packed {
    logic             vld;
    op_e              op;
    logic [OFS_W-1:0] n;
    logic [OFS_W-1:0] addr;
    logic [OFS_W-1:0] start;
    logic             hit;
    logic [OFS_W-1:0] off;
  } tok_t;

  // append write broadcast to the row
  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] idx;
    logic [OFS_W-1:0] len;
  } app_t;

endpackage

// ===== rtl/ffba_cell.sv =====
// ----------------------------------------------------------------------------
// ffba_cell
// one table entry: block length and used flag, checks the passing word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffba_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ffba_pkg::IDX_W-1:0] idx_i,
  input  logic [ffba_pkg::CNT_W-1:0] count_i,
  input  ffba_pkg::app_t            app_i,
  input  ffba_pkg::tok_t            tok_i,
  output ffba_pkg::tok_t            tok_o
);
  import ffba_pkg::*;

  logic [OFS_W-1:0] len_q, len_d;
  logic             used_q, used_d;
  tok_t             tok_q, tok_d;
  logic             live, fit, at;
  logic [OFS_W:0]   pay;

  always_comb begin
    live   = ({1'b0, idx_i} < count_i) && tok_i.vld && !tok_i.hit;
    fit    = !used_q && (len_q >= OFS_W'(HEADER_BYTES))
             && ((len_q - OFS_W'(HEADER_BYTES)) >= tok_i.n) && (tok_i.n != '0);
    pay    = {1'b0, tok_i.start} + (OFS_W+1)'(HEADER_BYTES);
    at     = (pay == {1'b0, tok_i.addr});
    len_d  = len_q;
    used_d = used_q;
    tok_d  = tok_i;
    if (live) begin
      if (tok_i.op == OP_ALLOC && fit) begin
        used_d    = 1'b1;
        tok_d.hit = 1'b1;
        tok_d.off = pay[OFS_W-1:0];
      end else if (tok_i.op == OP_FREE && at) begin
        used_d    = 1'b0;
        tok_d.hit = 1'b1;
        tok_d.off = '0;
      end else begin
        tok_d.start = tok_i.start + len_q;
      end
    end
    if (app_i.en && app_i.idx == {1'b0, idx_i}) begin
      len_d  = app_i.len;
      used_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    used_q <= used_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit heap allocator, block table kept in a row of cells
// ----------------------------------------------------------------------------
//  channel  signals                                              dir
//  in       in_valid_i in_stall_o operation_i request_bytes_i
//           block_address_i                                      in
//  out      out_valid_o out_stall_i payload_offset_o granted_o   out
//
//  each word walks the cell row, one cell per cycle; the result is
//  registered as the search word leaves the row and is then handed out
//  from the result state until it is taken
//  one word at a time; in_stall_o is high from acceptance until the result
//  has been taken, so every output stall holds off the next word
//  reset clears the block count, segment size, tail and the row's search
//  words; the table entries in the cells hold no reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_block_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [ffba_pkg::OFS_W-1:0]  request_bytes_i,
  input  logic [ffba_pkg::OFS_W-1:0]  block_address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ffba_pkg::OFS_W-1:0]  payload_offset_o,
  output logic                        granted_o
);
  import ffba_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [OFS_W-1:0] seg_q, seg_d;
  logic [OFS_W-1:0] tail_q, tail_d;
  logic [OFS_W-1:0] off_q, off_d;
  logic             gnt_q, gnt_d;
  tok_t             tok [MAX_BLOCKS+1];
  tok_t             launch;
  app_t             app;
  tok_t             fin;
  logic [SUM_W-1:0] need, step, grown, room;

  always_comb begin
    launch       = '0;
    launch.vld   = in_valid_i && state_q == ST_IDLE;
    launch.op    = op_e'(operation_i);
    launch.n     = request_bytes_i;
    launch.addr  = block_address_i;
  end

  assign tok[0] = launch;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    ffba_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(k)),
      .count_i (count_q),
      .app_i   (app),
      .tok_i   (tok[k]),
      .tok_o   (tok[k+1])
    );
  end

  assign fin = tok[MAX_BLOCKS];

  always_comb begin
    need  = SUM_W'(fin.n) + SUM_W'(HEADER_BYTES);
    step  = ((need + SUM_W'(GROW_STEP_BYTES - 1)) / SUM_W'(GROW_STEP_BYTES))
            * SUM_W'(GROW_STEP_BYTES);
    grown = SUM_W'(seg_q) + step;
    room  = SUM_W'(seg_q) - SUM_W'(tail_q);
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    seg_d   = seg_q;
    tail_d  = tail_q;
    off_d   = off_q;
    gnt_d   = gnt_q;
    app     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (fin.vld) begin
          state_d = ST_RESULT;
          off_d   = '0;
          gnt_d   = 1'b0;
          if (fin.hit) begin
            off_d = fin.off;
            gnt_d = 1'b1;
          end else if (fin.op == OP_ALLOC && fin.n != '0
                       && count_q < CNT_W'(MAX_BLOCKS)) begin
            if (seg_q >= tail_q && room >= need) begin
              gnt_d = 1'b1;
            end else if (grown <= SUM_W'(HEAP_LIMIT_BYTES)) begin
              gnt_d = 1'b1;
              seg_d = grown[OFS_W-1:0];
            end
            if (gnt_d) begin
              app.en  = 1'b1;
              app.idx = count_q;
              app.len = need[OFS_W-1:0];
              count_d = count_q + 1'b1;
              tail_d  = tail_q + need[OFS_W-1:0];
              off_d   = tail_q + OFS_W'(HEADER_BYTES);
            end
          end
        end
      end
      ST_RESULT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      seg_q   <= '0;
      tail_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      seg_q   <= seg_d;
      tail_q  <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    gnt_q <= gnt_d;
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = (state_q == ST_RESULT);
  assign payload_offset_o = off_q;
  assign granted_o        = gnt_q;

  a_fin_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin.vld |-> state_q == ST_RUN)
    else $error("search word left the row outside a search");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_BLOCKS))
    else $error("block count past table size");

  a_tail_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= seg_q)
    else $error("tail beyond segment end");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |-> payload_offset_o == '0)
    else $error("failed word carries an offset");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the first-fit block allocator: a queued driver and
// a monitor compare each result word against an in-bench allocator model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ffba_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1500000;
  localparam int unsigned RANDOM_ITEMS = 700;

  typedef struct packed {
    op_e              op;
    logic [OFS_W-1:0] n;
    logic [OFS_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [OFS_W-1:0] off;
    logic             granted;
  } grant_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             operation_i = 1'b0;
  logic [OFS_W-1:0] request_bytes_i = '0;
  logic [OFS_W-1:0] block_address_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [OFS_W-1:0] payload_offset_o;
  logic             granted_o;

  first_fit_block_allocator dut (.*);

  always #5 clk_i = ~clk_i;

  req_t        pending_reqs[$];
  grant_t      expected_grants[$];
  int unsigned live_offsets[$];

  // allocator model state
  int unsigned blk_len[MAX_BLOCKS];
  bit          blk_used[MAX_BLOCKS];
  int unsigned blk_cnt, seg_size, tail_ofs;

  int unsigned send_idle = 16, recv_idle = 49;
  int unsigned cycles = 0, accepted = 0, errors = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  function automatic grant_t model_step(req_t r);
    grant_t      g;
    int unsigned start, need, grown;
    g = '0;
    start = 0;
    if (r.op == OP_ALLOC) begin
      if (r.n == 0) return g;
      for (int k = 0; k < blk_cnt; k++) begin
        if (!blk_used[k] && blk_len[k] >= HEADER_BYTES && blk_len[k] - HEADER_BYTES >= r.n) begin
          blk_used[k] = 1'b1;
          g.off = OFS_W'(start + HEADER_BYTES);
          g.granted = 1'b1;
          return g;
        end
        start += blk_len[k];
      end
      if (blk_cnt >= MAX_BLOCKS) return g;
      need = r.n + HEADER_BYTES;
      if (seg_size < tail_ofs || seg_size - tail_ofs < need) begin
        grown = seg_size + ((need + GROW_STEP_BYTES - 1) / GROW_STEP_BYTES) * GROW_STEP_BYTES;
        if (grown > HEAP_LIMIT_BYTES) return g;
        seg_size = grown;
      end
      blk_len[blk_cnt] = need;
      blk_used[blk_cnt] = 1'b1;
      blk_cnt++;
      g.off = OFS_W'(tail_ofs + HEADER_BYTES);
      g.granted = 1'b1;
      tail_ofs += need;
      live_offsets.push_back(g.off);
    end else begin
      if (r.addr == 0) return g;
      for (int k = 0; k < blk_cnt; k++) begin
        if (start + HEADER_BYTES == r.addr) begin
          blk_used[k] = 1'b0;
          g.granted = 1'b1;
          return g;
        end
        start += blk_len[k];
      end
    end
    return g;
  endfunction

  // driver
  always @(posedge clk_i) begin
    req_t r;
    bit   took;
    took = in_valid_i && !in_stall_o;
    if (took) begin
      r.op = op_e'(operation_i);
      r.n = request_bytes_i;
      r.addr = block_address_i;
      expected_grants.push_back(model_step(r));
      accepted++;
    end
    if (!in_valid_i || took) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
        r = pending_reqs.pop_front();
        operation_i <= r.op;
        request_bytes_i <= r.n;
        block_address_i <= r.addr;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    grant_t g;
    if (out_valid_o && !out_stall_i) begin
      if (expected_grants.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: off=%0d granted=%0b",
                                   payload_offset_o, granted_o);
      end else begin
        g = expected_grants.pop_front();
        if (g.off !== payload_offset_o || g.granted !== granted_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected off=%0d granted=%0b, got off=%0d granted=%0b",
                     g.off, g.granted, payload_offset_o, granted_o);
        end
      end
    end
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_idle);
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (!hold_done && accepted == 120) begin
      hold_left <= 3000;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_req(op_e op, int unsigned n, int unsigned addr);
    req_t r;
    while (pending_reqs.size() > 2) @(posedge clk_i);
    r.op = op;
    r.n = n[OFS_W-1:0];
    r.addr = addr[OFS_W-1:0];
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_grants.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int unsigned n, a, pick;
    blk_cnt = 0;
    seg_size = 0;
    tail_ofs = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words
    queue_req(OP_ALLOC, 0, 0);
    queue_req(OP_ALLOC, 65536, 0);
    queue_req(OP_ALLOC, 1, 0);
    queue_req(OP_ALLOC, 100, 0);
    queue_req(OP_ALLOC, 4080, 0);
    queue_req(OP_FREE, 0, 0);
    queue_req(OP_FREE, 0, 12345);
    queue_req(OP_FREE, 0, 131071);
    queue_req(OP_FREE, 0, 33);
    queue_req(OP_FREE, 0, 33);
    queue_req(OP_ALLOC, 90, 0);
    queue_req(OP_ALLOC, 131071, 0);
    queue_req(OP_ALLOC, 60000, 0);
    queue_req(OP_FREE, 65536, 16);
    queue_req(OP_ALLOC, 1, 65535);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle = 49;
        recv_idle = 16;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (i == 300) drain();
      if ($urandom_range(99) < 35) begin
        pick = $urandom_range(99);
        if (pick < 70 && live_offsets.size() > 0)
          a = live_offsets[$urandom_range(live_offsets.size() - 1)];
        else if (pick < 80) a = 0;
        else a = $urandom_range(131071);
        queue_req(OP_FREE, $urandom_range(131071), a);
      end else begin
        pick = $urandom_range(99);
        if (pick < 5) n = 0;
        else if (pick < 10) n = $urandom_range(131071);
        else if (pick < 18) n = $urandom_range(20000, 1000);
        else n = $urandom_range(200, 1);
        queue_req(OP_ALLOC, n, $urandom_range(131071));
      end
    end
    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_grants.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== first_fit_block_allocator.f =====
rtl/ffba_pkg.sv
rtl/ffba_cell.sv
rtl/first_fit_block_allocator.sv
tb/tb.sv
